### hw/rtl/bode_pkg.sv
// ============================================================================
// bode_pkg
// Shared types, constants and code tables for the byte-offset delta encoder.
// ============================================================================
package bode_pkg;

    // Width of the running byte counter (8..32).
    localparam int COUNT_BITS     = 24;
    localparam int CAP_BITS       = 24;
    localparam int OUT_COUNT_BITS = 24;
    localparam int WIDE_BITS      = 34;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] ESCAPE_BYTE = 8'h80;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    // Bytes of headroom that must remain after an item.
    localparam logic [2:0] FULL_MARGIN = 3'd7;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Code class of one difference.
    typedef enum logic [1:0] {
        KIND_ONE,
        KIND_THREE,
        KIND_SEVEN,
        KIND_RANGE
    } t_kind;

    typedef struct packed {
        logic signed [31:0] pixel;
        logic               last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [7:0]                out_byte;
        logic                      byte_valid;
        logic                      last_of_run;
        logic [1:0]                status;
        logic [OUT_COUNT_BITS-1:0] byte_count;
        logic                      image_done;
    } t_out_item;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [31:0] delta;
        t_kind       kind;
        logic        last;
    } t_job;

    // Number of bytes in a code.
    function automatic logic [2:0] code_len(input t_kind kind);
        case (kind)
            KIND_ONE:   return 3'd1;
            KIND_THREE: return 3'd3;
            KIND_SEVEN: return 3'd7;
            default:    return 3'd0;
        endcase
    endfunction

    // Byte number idx of the code for difference d.
    function automatic logic [7:0] code_byte(input t_kind kind, input logic [2:0] idx,
                                             input logic [31:0] d);
        logic [7:0] b;
        b = d[7:0];
        case (kind)
            KIND_THREE: begin
                case (idx)
                    3'd0:    b = ESCAPE_BYTE;
                    3'd1:    b = d[7:0];
                    default: b = d[15:8];
                endcase
            end
            KIND_SEVEN: begin
                case (idx)
                    3'd0:    b = ESCAPE_BYTE;
                    3'd1:    b = ZERO_BYTE;
                    3'd2:    b = ESCAPE_BYTE;
                    3'd3:    b = d[7:0];
                    3'd4:    b = d[15:8];
                    3'd5:    b = d[23:16];
                    default: b = d[31:24];
                endcase
            end
            default: b = d[7:0];
        endcase
        return b;
    endfunction

    // Counter value as shown on the result port.
    function automatic logic [OUT_COUNT_BITS-1:0] out_count(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

### hw/rtl/bode_front.sv
// ============================================================================
// bode_front
// Takes pixels, forms the exact difference to the previous pixel and sorts it
// into a code class.
// ============================================================================
module bode_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bode_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_q_push,
    output bode_pkg::t_job    o_job
);
    import bode_pkg::*;

    logic signed [31:0] r_base;
    logic signed [31:0] n_base;
    logic               w_accept;
    logic signed [32:0] w_diff;
    logic [31:0]        w_d;
    logic               w_range_err;
    logic               w_fits8;
    logic               w_fits16;

    assign w_accept = i_push && !i_q_full;

    always_comb begin
        w_diff      = {i_in_item.pixel[31], i_in_item.pixel} - {r_base[31], r_base};
        w_d         = w_diff[31:0];
        // Outside +-(2^31-1): overflow of 32 bits, or exactly -2^31.
        w_range_err = (w_diff[32] != w_diff[31]) || (w_diff == {2'b11, 31'd0});
        w_fits8     = ((&w_d[31:7]) || !(|w_d[31:7])) && (w_d != 32'hFFFF_FF80);
        w_fits16    = ((&w_d[31:15]) || !(|w_d[31:15])) && (w_d != 32'hFFFF_8000);

        o_job.delta = w_d;
        o_job.last  = i_in_item.last_pixel;
        if (w_range_err) begin
            o_job.kind = KIND_RANGE;
        end else if (w_fits8) begin
            o_job.kind = KIND_ONE;
        end else if (w_fits16) begin
            o_job.kind = KIND_THREE;
        end else begin
            o_job.kind = KIND_SEVEN;
        end

        n_base = r_base;
        if (w_accept) begin
            n_base = i_in_item.last_pixel ? 32'sd0 : i_in_item.pixel;
        end
    end

    assign o_q_push = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'sd0;
        end else begin
            r_base <= n_base;
        end
    end

    // A new image always starts from a zero base.
    a_base_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_item.last_pixel |=> r_base == 32'sd0)
        else $error("base not cleared after last pixel");

endmodule

### hw/rtl/bode_queue.sv
// ============================================================================
// bode_queue
// Short job queue between the classifier and the byte serializer.
// ============================================================================
module bode_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bode_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output bode_pkg::t_job o_job
);
    import bode_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic [QUEUE_AW-1:0] n_wr;
    logic [QUEUE_AW-1:0] n_rd;
    logic [QUEUE_AW:0]   n_cnt;
    logic                w_push;
    logic                w_pop;

    localparam logic [QUEUE_AW:0]   DepthC = (QUEUE_AW+1)'(QUEUE_DEPTH);
    localparam logic [QUEUE_AW-1:0] LastC  = QUEUE_AW'(QUEUE_DEPTH - 1);

    assign o_full  = (r_cnt == DepthC);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LastC) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == LastC) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DepthC)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

### hw/rtl/bode_back.sv
// ============================================================================
// bode_back
// Keeps the byte count and error state of the image and sends each code out
// one byte per cycle while the receiver pops, through a result register.
// ============================================================================
module bode_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bode_pkg::CAP_BITS-1:0] i_cfg_wdata,
    input  logic                          i_q_empty,
    input  bode_pkg::t_job                i_job,
    output logic                          o_q_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output bode_pkg::t_out_item           o_out_item
);
    import bode_pkg::*;

    // image state
    logic [CAP_BITS-1:0]   r_cap;
    logic [COUNT_BITS-1:0] r_count;
    logic [1:0]            r_err;
    logic [COUNT_BITS-1:0] n_count;
    logic [1:0]            n_err;

    // code being sent
    logic                  r_busy;
    logic                  r_wbyte;
    logic [31:0]           r_wd;
    t_kind                 r_wkind;
    logic [2:0]            r_widx;
    logic [1:0]            r_wstatus;
    logic [COUNT_BITS-1:0] r_wcnt;
    logic                  r_wlast;
    logic                  n_busy;
    logic                  n_wbyte;
    logic [31:0]           n_wd;
    t_kind                 n_wkind;
    logic [2:0]            n_widx;
    logic [1:0]            n_wstatus;
    logic [COUNT_BITS-1:0] n_wcnt;
    logic                  n_wlast;

    // result register
    logic                  r_ovalid;
    t_out_item             r_out;
    logic                  n_ovalid;
    t_out_item             n_out;

    logic                  w_take;
    logic [2:0]            w_len;
    logic                  w_final;
    logic                  w_emit;
    logic                  w_done;
    logic                  w_load;
    logic [COUNT_BITS-1:0] w_newcnt;
    logic                  w_full;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    t_out_item             w_item;

    always_comb begin
        w_take    = !r_ovalid || i_pop;
        w_len     = code_len(r_wkind);
        w_final   = !r_wbyte || (r_widx == (w_len - 3'd1));
        w_emit    = r_busy && w_take;
        w_done    = w_emit && w_final;
        w_load    = (!r_busy || w_done) && !i_q_empty;
        w_cnt_inc = r_wcnt + 1'b1;
        w_newcnt  = r_count + COUNT_BITS'(code_len(i_job.kind));
        w_full    = (WIDE_BITS'(w_newcnt) + WIDE_BITS'(FULL_MARGIN)) > WIDE_BITS'(r_cap);

        w_item.out_byte    = r_wbyte ? code_byte(r_wkind, r_widx, r_wd) : 8'h00;
        w_item.byte_valid  = r_wbyte;
        w_item.last_of_run = w_final;
        w_item.status      = r_wstatus;
        w_item.byte_count  = out_count(r_wbyte ? w_cnt_inc : r_wcnt);
        w_item.image_done  = w_final && r_wlast;

        n_count   = r_count;
        n_err     = r_err;
        n_busy    = r_busy;
        n_wbyte   = r_wbyte;
        n_wd      = r_wd;
        n_wkind   = r_wkind;
        n_widx    = r_widx;
        n_wstatus = r_wstatus;
        n_wcnt    = r_wcnt;
        n_wlast   = r_wlast;
        n_ovalid  = r_ovalid;
        n_out     = r_out;

        if (w_emit) begin
            n_ovalid = 1'b1;
            n_out    = w_item;
            n_widx   = r_widx + 3'd1;
            n_wcnt   = w_cnt_inc;
            if (w_final) begin
                n_busy = 1'b0;
            end
        end else if (i_pop) begin
            n_ovalid = 1'b0;
        end

        if (w_load) begin
            n_wd    = i_job.delta;
            n_wkind = i_job.kind;
            n_widx  = 3'd0;
            n_wcnt  = r_count;
            n_wlast = i_job.last;
            if (r_err != STATUS_OK) begin
                // after an error only the last pixel answers
                n_busy    = i_job.last;
                n_wbyte   = 1'b0;
                n_wstatus = r_err;
                if (i_job.last) begin
                    n_count = '0;
                    n_err   = STATUS_OK;
                end
            end else if (i_job.kind == KIND_RANGE) begin
                n_busy    = 1'b1;
                n_wbyte   = 1'b0;
                n_wstatus = STATUS_RANGE;
                if (i_job.last) begin
                    n_count = '0;
                    n_err   = STATUS_OK;
                end else begin
                    n_err = STATUS_RANGE;
                end
            end else begin
                n_busy    = 1'b1;
                n_wbyte   = 1'b1;
                n_wstatus = w_full ? STATUS_FULL : STATUS_OK;
                if (i_job.last) begin
                    n_count = '0;
                    n_err   = STATUS_OK;
                end else begin
                    n_count = w_newcnt;
                    n_err   = w_full ? STATUS_FULL : STATUS_OK;
                end
            end
        end
    end

    assign o_q_pop    = w_load;
    assign o_empty    = !r_ovalid;
    assign o_out_item = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= '1;
            r_count  <= '0;
            r_err    <= STATUS_OK;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count  <= n_count;
            r_err    <= n_err;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wbyte   <= n_wbyte;
        r_wd      <= n_wd;
        r_wkind   <= n_wkind;
        r_widx    <= n_widx;
        r_wstatus <= n_wstatus;
        r_wcnt    <= n_wcnt;
        r_wlast   <= n_wlast;
        r_out     <= n_out;
    end

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err == STATUS_OK || r_err == STATUS_RANGE || r_err == STATUS_FULL)
        else $error("bad error state");

    a_idx_in_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_wbyte |-> r_widx < w_len)
        else $error("byte index past end of code");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && i_job.last |=> r_count == '0 && r_err == STATUS_OK)
        else $error("image state not cleared after last pixel");

endmodule

### hw/rtl/byte_offset_delta_encoder_core.sv
// ============================================================================
// byte_offset_delta_encoder_core
// Byte-offset delta encoder: signed pixels in, at most one code byte per result out.
// ============================================================================
// Each pixel is compared with the previous pixel of its image (zero for the
// first) and the difference goes out as a byte-offset code: one byte for
// +-127, 0x80 plus two little-endian bytes for +-32767, or 0x80 0x00 0x80
// plus four bytes up to +-(2^31-1). Each result carries at most one byte,
// the pixel's status, the running byte count of the image and end-of-code /
// end-of-image marks. A difference beyond +-(2^31-1) gives one byte-less
// result with status 1; a count that leaves fewer than 7 bytes of capacity
// flags status 2 on all that pixel's bytes. After either error pixels give
// no result until the last pixel of the image, which gives one byte-less
// result with the stored error; the last pixel always resets base, count and
// error. Both sides are queue style: push/full in, empty/pop out. Rate: the
// serializer sends one byte per cycle while the receiver pops, and a pixel
// dropped after an error sends nothing; with one-byte codes the block
// sustains one pixel per clock. A four-entry job queue between the classifier
// and the serializer soaks up long codes, and a result register lets a new
// byte go out in the cycle the old one is popped. The capacity register resets
// to all ones; users write it with i_cfg_we only while idle (not enforced).
module byte_offset_delta_encoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [bode_pkg::CAP_BITS-1:0] i_cfg_wdata,
    // pixel items
    input  logic                          i_push,
    output logic                          o_full,
    input  bode_pkg::t_in_item            i_in_item,
    // result items
    output logic                          o_empty,
    input  logic                          i_pop,
    output bode_pkg::t_out_item           o_out_item
);
    import bode_pkg::*;

    logic w_q_push;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;
    t_job w_job_in;
    t_job w_job_out;

    // front: difference and code class
    bode_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_in_item (i_in_item),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_job     (w_job_in)
    );

    // jobs waiting for the serializer
    bode_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_job_in),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .i_pop   (w_q_pop),
        .o_job   (w_job_out)
    );

    // back: count, status, error state and byte output
    bode_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (w_q_empty),
        .i_job       (w_job_out),
        .o_q_pop     (w_q_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out_item  (o_out_item)
    );

    assign o_full = w_q_full;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the byte-offset delta encoder: directed and random
// pixel images against a behavioral encoder, random stalls on both queues.
// ============================================================================
module tb;
    import bode_pkg::*;

    // Idle cycles (nothing accepted on either side) before the run is called hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles allowed after the last expected item for dropped pixels to drain.
    localparam int SETTLE_CYCLES = 32;
    // Receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES = 150;
    localparam longint MAX_DIFF = 64'sd2147483647;

    // ------------------------------------------------------------------------
    // Scoreboard: behavioral encoder plus the queue of bytes it expects.
    // ------------------------------------------------------------------------
    class code_scoreboard;
        t_out_item               pending_codes[$];
        logic signed [31:0]      base_pixel;
        logic [COUNT_BITS-1:0]   byte_total;
        logic [1:0]              err_code;
        logic [CAP_BITS-1:0]     capacity;
        int                      n_fail;

        function new();
            capacity = '1;
            n_fail   = 0;
            new_image();
        endfunction

        function void new_image();
            base_pixel = '0;
            byte_total = '0;
            err_code   = STATUS_OK;
        endfunction

        function t_out_item make_code(logic [7:0] b, logic valid, logic run_end,
                                      logic [1:0] st, logic done);
            t_out_item r;
            r.out_byte    = b;
            r.byte_valid  = valid;
            r.last_of_run = run_end;
            r.status      = st;
            r.byte_count  = OUT_COUNT_BITS'(byte_total);
            r.image_done  = done;
            return r;
        endfunction

        // Work out the bytes one accepted pixel produces.
        function void encode_pixel(t_in_item px);
            longint                diff;
            logic [31:0]           d;
            logic [7:0]            codes [7];
            int                    n;
            logic [1:0]            st;
            logic [COUNT_BITS-1:0] next_total;

            // latched error: swallow pixels, report once on the image's last one
            if (err_code != STATUS_OK) begin
                if (px.last_pixel) begin
                    pending_codes.push_back(make_code(8'h00, 1'b0, 1'b1, err_code, 1'b1));
                    new_image();
                end
                return;
            end

            diff = longint'($signed(px.pixel)) - longint'(base_pixel);
            if (diff > MAX_DIFF || diff < -MAX_DIFF) begin
                pending_codes.push_back(make_code(8'h00, 1'b0, 1'b1, STATUS_RANGE,
                                                  px.last_pixel));
                if (px.last_pixel)
                    new_image();
                else
                    err_code = STATUS_RANGE;
                return;
            end

            d = diff[31:0];
            if (diff >= -127 && diff <= 127) begin
                codes[0] = d[7:0];
                n = 1;
            end else if (diff >= -32767 && diff <= 32767) begin
                codes[0] = ESCAPE_BYTE;
                codes[1] = d[7:0];
                codes[2] = d[15:8];
                n = 3;
            end else begin
                codes[0] = ESCAPE_BYTE;
                codes[1] = ZERO_BYTE;
                codes[2] = ESCAPE_BYTE;
                codes[3] = d[7:0];
                codes[4] = d[15:8];
                codes[5] = d[23:16];
                codes[6] = d[31:24];
                n = 7;
            end

            // headroom test on the wrapped count after this pixel
            next_total = byte_total + COUNT_BITS'(n);
            st = (longint'(next_total) + 7 > longint'(capacity)) ? STATUS_FULL : STATUS_OK;

            for (int k = 0; k < n; k++) begin
                byte_total = byte_total + 1'b1;
                pending_codes.push_back(make_code(codes[k], 1'b1, k == n - 1, st,
                                                  (k == n - 1) && px.last_pixel));
            end
            base_pixel = px.pixel;

            if (px.last_pixel)
                new_image();
            else if (st != STATUS_OK)
                err_code = st;
        endfunction

        function void report(string msg);
            n_fail++;
            if (n_fail <= 10)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        // Compare one popped item with the oldest expected one.
        function void check_code(t_out_item got);
            t_out_item exp_code;
            if (pending_codes.size() == 0) begin
                report($sformatf("unexpected item byte=%02h valid=%0b status=%0d count=%0d",
                                 got.out_byte, got.byte_valid, got.status, got.byte_count));
                return;
            end
            exp_code = pending_codes.pop_front();
            if (got.out_byte    !== exp_code.out_byte    ||
                got.byte_valid  !== exp_code.byte_valid  ||
                got.last_of_run !== exp_code.last_of_run ||
                got.status      !== exp_code.status      ||
                got.byte_count  !== exp_code.byte_count  ||
                got.image_done  !== exp_code.image_done)
                report($sformatf({"byte/valid/run_end/status/count/done exp ",
                                  "%02h/%0b/%0b/%0d/%0d/%0b got %02h/%0b/%0b/%0d/%0d/%0b"},
                                 exp_code.out_byte, exp_code.byte_valid,
                                 exp_code.last_of_run, exp_code.status,
                                 exp_code.byte_count, exp_code.image_done,
                                 got.out_byte, got.byte_valid, got.last_of_run,
                                 got.status, got.byte_count, got.image_done));
        endfunction

        function void check_leftover();
            while (pending_codes.size() != 0) begin
                t_out_item r;
                r = pending_codes.pop_front();
                report($sformatf("expected item never came: byte=%02h status=%0d count=%0d",
                                 r.out_byte, r.status, r.byte_count));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CAP_BITS-1:0] cfg_wdata;
    logic                push;
    logic                full;
    t_in_item            in_item;
    logic                empty;
    logic                pop;
    t_out_item           out_item;

    code_scoreboard board;
    bit             fast_mode;      // no idle gaps on either side
    int             hold_request;   // one-shot long receiver hold-off
    int             idle_cycles;

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    byte_offset_delta_encoder_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_in_item   (in_item),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_item  (out_item)
    );

    // Watchdog: ends the run if neither queue moves for too long.
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: pops items with random gaps; honors a one-shot long hold-off
    // so the job queue fills and the block pushes back on the sender.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request > 0)
                gap = hold_request;
            else
                gap = fast_mode ? 0 : $urandom_range(0, 15);
            hold_request = 0;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            board.check_code(out_item);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one pixel item; push stays high across back-to-back items.
    task automatic push_pixel(input logic [31:0] value, input logic last);
        t_in_item px;
        int       gap;
        px.pixel      = value;
        px.last_pixel = last;
        gap = fast_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= px;
        do @(posedge clk); while (full);
        board.encode_pixel(px);
    endtask

    // Stop offering, wait for every expected item, then let dropped pixels
    // (which give no item) work through the job queue.
    task automatic drain();
        push <= 1'b0;
        while (board.pending_codes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic set_capacity(input logic [CAP_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.capacity = value;
    endtask

    // Next pixel of a random image: mostly small steps, some escapes, some
    // steps at the code boundaries and the odd out-of-range jump.
    function automatic logic [31:0] next_pixel(input logic [31:0] prev);
        int          sel;
        logic [31:0] step;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            return prev + 32'(int'($urandom_range(0, 254)) - 127);
        end else if (sel < 75) begin
            return prev + 32'(int'($urandom_range(0, 65534)) - 32767);
        end else if (sel < 83) begin
            case ($urandom_range(0, 3))
                0:       step = 32'd127;
                1:       step = 32'd128;
                2:       step = 32'd32767;
                default: step = 32'd32768;
            endcase
            return $urandom_range(0, 1) ? prev + step : prev - step;
        end else if (sel < 93) begin
            return $urandom();
        end else if (sel < 97) begin
            // widest legal difference either way
            return prev + ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0001);
        end
        // exact difference of +-2^31: always out of range
        return prev + 32'h8000_0000;
    endfunction

    // Whole images of random length; the last image is cut to the quota.
    task automatic run_images(input int quota);
        int          sent;
        int          len;
        logic [31:0] prev;
        sent = 0;
        prev = '0;
        while (sent < quota) begin
            len = $urandom_range(1, 12);
            if (len > quota - sent)
                len = quota - sent;
            for (int i = 0; i < len; i++) begin
                prev = next_pixel(prev);
                push_pixel(prev, i == len - 1);
                sent++;
            end
            prev = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        board        = new();
        fast_mode    = 1'b0;
        hold_request = 0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        push         <= 1'b0;
        in_item      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset capacity: every code length at its limits.
        push_pixel(32'd0, 1'b0);             // zero difference
        push_pixel(32'd127, 1'b0);           // +127, one byte
        push_pixel(32'd0, 1'b0);             // -127, one byte
        push_pixel(32'd128, 1'b0);           // +128, first escape
        push_pixel(-32'sd32639, 1'b0);       // -32767
        push_pixel(32'd128, 1'b0);           // +32767
        push_pixel(32'd32896, 1'b0);         // +32768, long escape
        push_pixel(32'd128, 1'b0);           // -32768
        push_pixel(32'h7FFF_FFFF, 1'b0);     // largest pixel
        push_pixel(32'd0, 1'b0);             // -(2^31-1), widest legal
        push_pixel(32'h8000_0000, 1'b0);     // -2^31: out of range, error latched
        push_pixel(32'd5, 1'b0);             // swallowed
        push_pixel(32'd7, 1'b1);             // last pixel reports stored error
        push_pixel(32'h8000_0001, 1'b0);     // fresh image
        push_pixel(32'h7FFF_FFFF, 1'b1);     // out of range on the last pixel
        push_pixel(32'hFFFF_FFFF, 1'b1);     // one-pixel image
        drain();

        // Tight capacity: buffer-full error, then swallowed pixels.
        set_capacity(24'd10);
        push_pixel(32'd1, 1'b0);
        push_pixel(32'd1000, 1'b0);          // count 4 leaves under 7 bytes
        push_pixel(32'd5, 1'b0);
        push_pixel(32'd6, 1'b1);
        drain();

        // Zero capacity: every pixel is full, last pixel still emits.
        set_capacity(24'd0);
        push_pixel(32'd0, 1'b1);
        push_pixel(32'd3, 1'b1);
        drain();

        // Random phases, each under its own capacity and traffic pattern.
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_capacity('1);
                1: begin
                    set_capacity('1);
                    fast_mode = 1'b1;
                end
                2: begin
                    // receiver stalls while the sender keeps offering
                    set_capacity('1);
                    fast_mode    = 1'b1;
                    hold_request = HOLD_CYCLES;
                end
                3: set_capacity(24'd0);
                4: set_capacity(CAP_BITS'($urandom_range(20, 120)));
                5: set_capacity(CAP_BITS'($urandom()));
                default: set_capacity(CAP_BITS'($urandom_range(0, 300)));
            endcase
            run_images(14);
            drain();
            fast_mode = 1'b0;
        end

        board.check_leftover();
        if (board.n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
